// ----- src/tram_pkg.sv -----
`default_nettype none

package tram_pkg;

  localparam int unsigned TileRamBytes = 2048;
  localparam int unsigned OffsetW      = 11;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 1;

  localparam int unsigned TileColW   = 6;
  localparam int unsigned TileRowW   = 7;
  localparam int unsigned TileCodeW  = 9;
  localparam int unsigned ColorIdxW  = 7;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCharBank   = 2'd0,
    CfgColorTable = 2'd1,
    CfgPalette    = 2'd2,
    CfgFlipScreen = 2'd3
  } cfg_idx_e;

  localparam logic ReqWrite = 1'b0;
  localparam logic ReqFetch = 1'b1;

  typedef struct packed {
    logic               en;
    logic [OffsetW-1:0] code_addr;
    logic [OffsetW-1:0] color_addr;
  } tram_rd_req_t;

  typedef struct packed {
    logic               en;
    logic [OffsetW-1:0] addr;
    logic [ByteW-1:0]   data;
  } tram_wr_req_t;

endpackage

`default_nettype wire

// ----- src/tram_if.sv -----
`default_nettype none

interface tram_req_if;
  import tram_pkg::*;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [OffsetW-1:0] ram_offset;
  logic [ByteW-1:0]   write_byte;

  modport source (output valid, req_type, ram_offset, write_byte, input ready);
  modport sink   (input valid, req_type, ram_offset, write_byte, output ready);
endinterface

interface tram_rsp_if;
  import tram_pkg::*;
  logic                        valid;
  logic                        ready;
  logic                        tile_valid;
  logic [TileColW-1:0]         tile_col;
  logic signed [TileRowW-1:0]  tile_row;
  logic [TileCodeW-1:0]        tile_code;
  logic [ColorIdxW-1:0]        color_index;
  logic                        tile_flip;

  modport source (output valid, tile_valid, tile_col, tile_row, tile_code, color_index,
                  tile_flip, input ready);
  modport sink   (input valid, tile_valid, tile_col, tile_row, tile_code, color_index,
                  tile_flip, output ready);
endinterface

`default_nettype wire

// ----- src/tram_store.sv -----
`default_nettype none

// two identical copies of the tile RAM, one read port each
module tram_store import tram_pkg::*; #(
  parameter int unsigned TILE_RAM_BYTES = TileRamBytes
) (
  input  wire logic         clk_i,
  input  wire tram_wr_req_t wr_i,
  input  wire tram_rd_req_t rd_i,
  output logic [ByteW-1:0]  code_byte_o,
  output logic [ByteW-1:0]  color_byte_o
);

  localparam int unsigned AddrW = $clog2(TILE_RAM_BYTES);

  logic [ByteW-1:0] code_mem  [TILE_RAM_BYTES];
  logic [ByteW-1:0] color_mem [TILE_RAM_BYTES];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      code_mem[wr_i.addr[AddrW-1:0]]  <= wr_i.data;
      color_mem[wr_i.addr[AddrW-1:0]] <= wr_i.data;
    end
    if (rd_i.en) begin
      code_byte_o  <= code_mem[rd_i.code_addr[AddrW-1:0]];
      color_byte_o <= color_mem[rd_i.color_addr[AddrW-1:0]];
    end
  end

endmodule

`default_nettype wire

// ----- src/tile_ram_layout_attribute_fetch.sv -----
`default_nettype none

// channel  dir  modport  beat
// req_i    in   sink     write byte or fetch, one per beat
// rsp_o    out  source   one beat per fetch, none per write
// cfg      in   plain    we/idx/data, takes effect next cycle
//
// Two-stage pipe: RAM read (both copies) into s1, then out_valid_q register.
// One beat accepted per cycle unless rsp_o stalls; rsp_o.valid = out_valid_q.
// rst_ni clears control and config; RAM contents are undefined until written.
// A stalled rsp_o holds the read stage, which then backpressures req_i.
module tile_ram_layout_attribute_fetch import tram_pkg::*; #(
  parameter int unsigned TILE_RAM_BYTES = TileRamBytes
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  tram_req_if.sink                 req_i,
  tram_rsp_if.source               rsp_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  logic char_bank_q, color_table_q, palette_q, flip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_bank_q   <= 1'b0;
      color_table_q <= 1'b0;
      palette_q     <= 1'b0;
      flip_q        <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgCharBank:   char_bank_q   <= cfg_data_i[0];
        CfgColorTable: color_table_q <= cfg_data_i[0];
        CfgPalette:    palette_q     <= cfg_data_i[0];
        CfgFlipScreen: flip_q        <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // stage 1: decode and RAM read
  logic                        s1_valid_q;
  logic                        s1_disp_q, s1_disp_d;
  logic                        s1_bank_q, s1_bank_d;
  logic [TileColW-1:0]         s1_col_q, s1_col_d;
  logic signed [TileRowW-1:0]  s1_row_q, s1_row_d;
  logic                        s1_move, accept, fetch;
  logic                        out_valid_q;

  assign s1_move     = !out_valid_q || rsp_o.ready;
  assign req_i.ready = !s1_valid_q || s1_move;
  assign accept      = req_i.valid && req_i.ready;
  assign fetch       = accept && (req_i.req_type == ReqFetch);

  logic [4:0]         col;
  logic [5:0]         row;
  logic [OffsetW-1:0] color_addr;
  tram_wr_req_t       wr_req;
  tram_rd_req_t       rd_req;
  logic [ByteW-1:0]   code_byte, color_byte;

  assign col = req_i.ram_offset[4:0];
  assign row = req_i.ram_offset[10:5];

  always_comb begin
    s1_disp_d  = (row >= 6'd2) && (row < 6'd60);
    s1_bank_d  = row < 6'd58;
    color_addr = req_i.ram_offset + OffsetW'(128);
    if (row < 6'd56) begin
      s1_col_d   = TileColW'(col) + TileColW'(2);
      s1_row_d   = TileRowW'(row);
      color_addr = OffsetW'(col);
    end else if (row < 6'd58) begin
      s1_col_d = TileColW'(row) - TileColW'(22);
      s1_row_d = TileRowW'(col) - TileRowW'(2);
    end else begin
      s1_col_d = TileColW'(row) - TileColW'(58);
      s1_row_d = TileRowW'(col) - TileRowW'(2);
    end
  end

  assign wr_req = '{en: accept && (req_i.req_type == ReqWrite),
                    addr: req_i.ram_offset, data: req_i.write_byte};
  assign rd_req = '{en: fetch, code_addr: req_i.ram_offset, color_addr: color_addr};

  tram_store #(
    .TILE_RAM_BYTES(TILE_RAM_BYTES)
  ) u_store (
    .clk_i       (clk_i),
    .wr_i        (wr_req),
    .rd_i        (rd_req),
    .code_byte_o (code_byte),
    .color_byte_o(color_byte)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= fetch;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fetch) begin
      s1_disp_q <= s1_disp_d;
      s1_bank_q <= s1_bank_d;
      s1_col_q  <= s1_col_d;
      s1_row_q  <= s1_row_d;
    end
  end

  // stage 2: attributes into the output register
  logic                       tv_d, tf_d;
  logic [TileColW-1:0]        tc_d;
  logic signed [TileRowW-1:0] tr_d;
  logic [TileCodeW-1:0]       code_d;
  logic [ColorIdxW-1:0]       ci_d;

  always_comb begin
    tv_d   = s1_disp_q;
    tf_d   = flip_q;
    tc_d   = flip_q ? TileColW'(35) - s1_col_q : s1_col_q;
    tr_d   = flip_q ? TileRowW'(55) - s1_row_q : s1_row_q;
    code_d = {s1_bank_q & char_bank_q, code_byte};
    ci_d   = {palette_q, color_table_q, color_byte[4:0]};
    if (!s1_disp_q) begin
      tf_d   = 1'b0;
      tc_d   = '0;
      tr_d   = '0;
      code_d = '0;
      ci_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move && s1_valid_q) begin
      rsp_o.tile_valid  <= tv_d;
      rsp_o.tile_col    <= tc_d;
      rsp_o.tile_row    <= tr_d;
      rsp_o.tile_code   <= code_d;
      rsp_o.color_index <= ci_d;
      rsp_o.tile_flip   <= tf_d;
    end
  end

  assign rsp_o.valid = out_valid_q;

endmodule

`default_nettype wire
